// ===== design/uvd_pkg.sv =====
// Shared types and constants for the UVC payload deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package uvd_pkg;

  localparam int FRAME_LENGTH_BITS    = 24;
  localparam int TRANSFER_LENGTH_BITS = 16;
  localparam int SUM_BITS = ((FRAME_LENGTH_BITS > TRANSFER_LENGTH_BITS) ?
                             FRAME_LENGTH_BITS : TRANSFER_LENGTH_BITS) + 1;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_FRAME_LENGTH = 0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_FRAME_LENGTH = 1;

  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_FRAME_END  = 2'd1;
  localparam logic [1:0] KIND_CLEAR_HALT = 2'd2;

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_STALL = 1'b1;

  localparam logic [7:0] INFO_FID = 8'h01;
  localparam logic [7:0] INFO_EOF = 8'h02;
  localparam logic [7:0] INFO_ERR = 8'h40;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                            cmd;
    logic [7:0]                      data_byte;
    logic                            first_byte;
    logic [TRANSFER_LENGTH_BITS-1:0] transfer_length;
  } item_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [7:0]                   out_byte;
    logic [FRAME_LENGTH_BITS-1:0] frame_length;
    logic                         frame_good;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic [FRAME_LENGTH_BITS-1:0] min_frame_length;
    logic [FRAME_LENGTH_BITS-1:0] max_frame_length;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/uvd_parser.sv =====
// Payload header parser and frame tracker: state update and up to two results per beat.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uvd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_go,
  input  wire uvd_pkg::item_t  item,
  input  wire uvd_pkg::cfg_t   cfg,
  output logic [1:0]           push_cnt,
  output uvd_pkg::result_t     res0,
  output uvd_pkg::result_t     res1
);
  import uvd_pkg::*;

  logic                            fid_seen_r, fid_seen_nxt;
  logic                            cur_fid_r, cur_fid_nxt;
  logic [FRAME_LENGTH_BITS-1:0]    frame_size_r, frame_size_nxt;
  logic [TRANSFER_LENGTH_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]                      hdr_len_r, hdr_len_nxt;
  logic                            pl_valid_r, pl_valid_nxt;
  logic                            pl_acc_r, pl_acc_nxt;
  logic                            pl_eof_r, pl_eof_nxt;

  always_comb begin
    logic [TRANSFER_LENGTH_BITS-1:0] pos;
    logic [TRANSFER_LENGTH_BITS-1:0] len;
    logic [TRANSFER_LENGTH_BITS-1:0] hdr_ext;
    logic [TRANSFER_LENGTH_BITS-1:0] dlen;
    logic [SUM_BITS-1:0]             fill;
    logic                            fid;
    logic                            close_req;
    result_t                         r [2];
    logic [1:0]                      n;

    fid_seen_nxt   = fid_seen_r;
    cur_fid_nxt    = cur_fid_r;
    frame_size_nxt = frame_size_r;
    byte_pos_nxt   = byte_pos_r;
    hdr_len_nxt    = hdr_len_r;
    pl_valid_nxt   = pl_valid_r;
    pl_acc_nxt     = pl_acc_r;
    pl_eof_nxt     = pl_eof_r;
    len     = item.transfer_length;
    hdr_ext = TRANSFER_LENGTH_BITS'(hdr_len_r);
    dlen    = len - hdr_ext;
    fid     = |(item.data_byte & INFO_FID);
    pos     = '0;
    fill    = '0;
    close_req = 1'b0;
    n       = 2'd0;
    r[0]    = '0;
    r[1]    = '0;

    if (item_go) begin
      if (item.cmd == CMD_STALL) begin
        byte_pos_nxt = '0;
        pl_valid_nxt = 1'b0;
        pl_acc_nxt   = 1'b0;
        pl_eof_nxt   = 1'b0;
        r[0].kind    = KIND_CLEAR_HALT;
        n            = 2'd1;
      end else if (item.first_byte || (byte_pos_r != '0)) begin
        if (item.first_byte) begin
          pos          = '0;
          pl_valid_nxt = 1'b0;
          pl_acc_nxt   = 1'b0;
          pl_eof_nxt   = 1'b0;
        end else begin
          pos = byte_pos_r;
        end
        byte_pos_nxt = (pos != '1) ? pos + 1'b1 : pos;

        if (pos == '0) begin
          hdr_len_nxt = item.data_byte;
        end else if (pos == TRANSFER_LENGTH_BITS'(1)) begin
          if ((len >= TRANSFER_LENGTH_BITS'(2)) && (hdr_len_r >= 8'd2) &&
              (hdr_ext <= len) && ((item.data_byte & INFO_ERR) == 8'd0)) begin
            pl_valid_nxt = 1'b1;
            pl_eof_nxt   = |(item.data_byte & INFO_EOF);
            // A frame-id toggle closes the running frame before this payload counts.
            if (fid_seen_r && (fid != cur_fid_r)) begin
              if (frame_size_nxt != '0) begin
                r[0].kind         = KIND_FRAME_END;
                r[0].frame_length = frame_size_nxt;
                r[0].frame_good   = frame_size_nxt >= cfg.min_frame_length;
                n                 = 2'd1;
              end
              frame_size_nxt = '0;
            end
            cur_fid_nxt  = fid;
            fid_seen_nxt = 1'b1;
            fill = SUM_BITS'(frame_size_nxt) + SUM_BITS'(dlen);
            pl_acc_nxt = (dlen != '0) && (fill <= SUM_BITS'(cfg.max_frame_length));
            // Header-only transfer with end of frame closes right away.
            close_req = (len == TRANSFER_LENGTH_BITS'(2)) && pl_eof_nxt;
          end
        end else if (pl_valid_nxt && (pos < len)) begin
          if (pl_acc_nxt && (pos >= hdr_ext)) begin
            r[0].kind      = KIND_DATA;
            r[0].out_byte  = item.data_byte;
            n              = 2'd1;
            frame_size_nxt = frame_size_nxt + 1'b1;
          end
          close_req = (pos == len - 1'b1) && pl_eof_nxt;
        end

        if (close_req) begin
          if (frame_size_nxt != '0) begin
            r[n[0]].kind         = KIND_FRAME_END;
            r[n[0]].out_byte     = '0;
            r[n[0]].frame_length = frame_size_nxt;
            r[n[0]].frame_good   = frame_size_nxt >= cfg.min_frame_length;
            n = n + 2'd1;
          end
          frame_size_nxt = '0;
        end
      end
    end

    if (n == 2'd1) begin
      r[0].last = 1'b1;
    end else if (n == 2'd2) begin
      r[1].last = 1'b1;
    end
    push_cnt = n;
    res0     = r[0];
    res1     = r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fid_seen_r   <= 1'b0;
      cur_fid_r    <= 1'b0;
      frame_size_r <= '0;
      byte_pos_r   <= '0;
      hdr_len_r    <= '0;
      pl_valid_r   <= 1'b0;
      pl_acc_r     <= 1'b0;
      pl_eof_r     <= 1'b0;
    end else begin
      fid_seen_r   <= fid_seen_nxt;
      cur_fid_r    <= cur_fid_nxt;
      frame_size_r <= frame_size_nxt;
      byte_pos_r   <= byte_pos_nxt;
      hdr_len_r    <= hdr_len_nxt;
      pl_valid_r   <= pl_valid_nxt;
      pl_acc_r     <= pl_acc_nxt;
      pl_eof_r     <= pl_eof_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/uvd_out_fifo.sv =====
// Small result queue taking up to two results per cycle and giving one unless stalled.
// Depends on uvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uvd_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_cnt,
  input  wire uvd_pkg::result_t push0,
  input  wire uvd_pkg::result_t push1,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output uvd_pkg::result_t      out_res
);
  import uvd_pkg::*;

  result_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // Room is judged without the pop of this cycle so it never depends on out_stall.
  assign room      = (cnt_r <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_BITS'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_BITS'(pop);
    cnt_nxt    = cnt_r + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/uvc_payload_deframer.sv =====
// A beat is registered in item_r, parsed once the result queue has room, and its
// results are written into that queue, whose head drives out_valid and the outputs.
// Throughput: one input beat per cycle; the parser emits at most two results per beat
// into a four-entry result queue, and input stalls only when that queue lacks two free slots.
// Reset: synchronous active-low rst_n clears all frame and transfer state, empties the
// queue, and sets min_frame_length to 0 and max_frame_length to all ones.
`timescale 1ns / 1ps
`default_nettype none
module uvc_payload_deframer (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic                                      in_cmd,
  input  wire logic [7:0]                                in_data_byte,
  input  wire logic                                      in_first_byte,
  input  wire logic [uvd_pkg::TRANSFER_LENGTH_BITS-1:0]  in_transfer_length,
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic [1:0]                                     out_kind,
  output logic [7:0]                                     out_out_byte,
  output logic [uvd_pkg::FRAME_LENGTH_BITS-1:0]          out_frame_length,
  output logic                                           out_frame_good,
  output logic                                           out_last,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [uvd_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire logic [uvd_pkg::FRAME_LENGTH_BITS-1:0]     cfg_data
);
  import uvd_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  logic    in_vld_r;
  logic    room;
  logic    go;
  logic    in_acc;
  logic [1:0] push_cnt;
  result_t res0, res1, out_res;

  assign cfg_ready = 1'b1;
  assign go        = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_frame_length <= '0;
      cfg_r.max_frame_length <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_FRAME_LENGTH: cfg_r.min_frame_length <= cfg_data;
        REG_MAX_FRAME_LENGTH: cfg_r.max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd             <= in_cmd;
      item_r.data_byte       <= in_data_byte;
      item_r.first_byte      <= in_first_byte;
      item_r.transfer_length <= in_transfer_length;
    end
  end

  uvd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_go  (go),
    .item     (item_r),
    .cfg      (cfg_r),
    .push_cnt (push_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  uvd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_out_byte     = out_res.out_byte;
  assign out_frame_length = out_res.frame_length;
  assign out_frame_good   = out_res.frame_good;
  assign out_last         = out_res.last;

endmodule
`default_nettype wire

// ===== bench/tb_uvc_payload_deframer.sv =====
// Self-checking testbench for uvc_payload_deframer: a directed table, then randomized
// bulk transfers under several frame length settings, checked beat by beat.
// Depends on design/uvd_pkg.sv and design/uvc_payload_deframer.sv.
`timescale 1ns / 1ps
module tb_uvc_payload_deframer;
  import uvd_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 95;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_SILENT, ROW_TYPED} row_check_t;

  typedef struct packed {
    row_check_t how;
    result_t    typed;
  } beat_check_t;

  typedef struct packed {
    item_t      beat;
    row_check_t how;
    result_t    typed;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = CMD_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic in_first_byte = 1'b0;
  logic [TRANSFER_LENGTH_BITS-1:0] in_transfer_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic [FRAME_LENGTH_BITS-1:0] out_frame_length;
  logic out_frame_good;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [FRAME_LENGTH_BITS-1:0] cfg_data = '0;

  uvc_payload_deframer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_data_byte(in_data_byte), .in_first_byte(in_first_byte),
    .in_transfer_length(in_transfer_length),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_out_byte(out_out_byte), .out_frame_length(out_frame_length),
    .out_frame_good(out_frame_good), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Deframer state as the predictor sees it.
  logic [FRAME_LENGTH_BITS-1:0]    min_len = '0;
  logic [FRAME_LENGTH_BITS-1:0]    max_len = '1;
  logic                            fid_seen = 1'b0;
  logic                            cur_fid = 1'b0;
  logic [FRAME_LENGTH_BITS-1:0]    frame_size = '0;
  logic [TRANSFER_LENGTH_BITS-1:0] open_pos = '0;
  logic [7:0]                      hdr_len = '0;
  logic                            pay_valid = 1'b0;
  logic                            pay_taken = 1'b0;
  logic                            pay_eof = 1'b0;

  result_t     step_out[$];
  result_t     deframed_q[$];
  beat_check_t typed_q[$];
  script_row_t script[$];

  logic next_fid = 1'b0;
  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   beats_sent = 0;

  function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] b,
                                        input logic [FRAME_LENGTH_BITS-1:0] len,
                                        input logic good);
    result_t r;
    r = '0;
    r.kind = kind;
    r.out_byte = b;
    r.frame_length = len;
    r.frame_good = good;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void close_frame();
    if (frame_size != 0)
      step_out.insert(step_out.size(),
                      mk_result(KIND_FRAME_END, 8'h00, frame_size, frame_size >= min_len));
    frame_size = '0;
  endfunction

  // Works out the results one accepted beat causes; the last flag is applied by the caller.
  function automatic void deframe_beat(input item_t it);
    logic [TRANSFER_LENGTH_BITS-1:0] pos;
    logic [TRANSFER_LENGTH_BITS-1:0] dlen;
    logic [FRAME_LENGTH_BITS:0]      fill;
    logic                            fid;
    step_out.delete();
    if (it.cmd == CMD_STALL) begin
      open_pos = '0;
      pay_valid = 1'b0;
      pay_taken = 1'b0;
      pay_eof = 1'b0;
      step_out.insert(step_out.size(), mk_result(KIND_CLEAR_HALT, 8'h00, '0, 1'b0));
    end else if (it.first_byte || open_pos != 0) begin
      if (it.first_byte) begin
        open_pos = '0;
        pay_valid = 1'b0;
        pay_taken = 1'b0;
        pay_eof = 1'b0;
      end
      pos = open_pos;
      if (open_pos != '1)
        open_pos = open_pos + 1'b1;
      if (pos == 0) begin
        hdr_len = it.data_byte;
      end else if (pos == 1) begin
        if (it.transfer_length >= 2 && hdr_len >= 2 && hdr_len <= it.transfer_length &&
            (it.data_byte & INFO_ERR) == 0) begin
          fid = |(it.data_byte & INFO_FID);
          dlen = it.transfer_length - hdr_len;
          pay_valid = 1'b1;
          pay_eof = |(it.data_byte & INFO_EOF);
          if (fid_seen && fid != cur_fid)
            close_frame();
          cur_fid = fid;
          fid_seen = 1'b1;
          fill = frame_size + dlen;
          pay_taken = (dlen != 0) && (fill <= max_len);
          if (it.transfer_length == 2 && pay_eof)
            close_frame();
        end
      end else if (pay_valid && pos < it.transfer_length) begin
        if (pay_taken && pos >= hdr_len) begin
          step_out.insert(step_out.size(), mk_result(KIND_DATA, it.data_byte, '0, 1'b0));
          frame_size = frame_size + 1'b1;
        end
        if (pos == it.transfer_length - 1 && pay_eof)
          close_frame();
      end
    end
  endfunction

  function automatic void report_mismatch(input string why, input result_t want,
                                          input result_t got);
    if (mismatches < 10) begin
      $display("%0t %s: expected kind=%0d byte=%02h len=%0d good=%0d last=%0d,",
               $time, why, want.kind, want.out_byte, want.frame_length, want.frame_good,
               want.last);
      $display("    got kind=%0d byte=%02h len=%0d good=%0d last=%0d",
               got.kind, got.out_byte, got.frame_length, got.frame_good, got.last);
    end
    mismatches++;
  endfunction

  // Prediction on every accepted input beat, then the check of every accepted result beat.
  always @(posedge clk) begin : track
    item_t       it;
    beat_check_t bc;
    result_t     got;
    result_t     want;
    result_t     r;
    if (rst_n && in_valid && !in_stall) begin
      it.cmd = in_cmd;
      it.data_byte = in_data_byte;
      it.first_byte = in_first_byte;
      it.transfer_length = in_transfer_length;
      bc = typed_q.pop_front();
      deframe_beat(it);
      case (bc.how)
        ROW_PREDICTED: begin
          for (int i = 0; i < step_out.size(); i++) begin
            r = step_out[i];
            r.last = (i == step_out.size() - 1);
            deframed_q.insert(deframed_q.size(), r);
          end
        end
        ROW_TYPED: deframed_q.insert(deframed_q.size(), bc.typed);
        default: ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_kind;
      got.out_byte = out_out_byte;
      got.frame_length = out_frame_length;
      got.frame_good = out_frame_good;
      got.last = out_last;
      if (deframed_q.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = deframed_q.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.frame_length !== want.frame_length || got.frame_good !== want.frame_good ||
            got.last !== want.last)
          report_mismatch("wrong result", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("uvc_payload_deframer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Random receiver backpressure in bursts, started only while idle_on is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(input item_t it, input row_check_t how, input result_t typed);
    beat_check_t bc;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    bc.how = how;
    bc.typed = typed;
    typed_q.insert(typed_q.size(), bc);
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_data_byte <= it.data_byte;
    in_first_byte <= it.first_byte;
    in_transfer_length <= it.transfer_length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic add_row(input logic cmd, input logic [7:0] b, input logic fb,
                         input logic [TRANSFER_LENGTH_BITS-1:0] len, input row_check_t how,
                         input result_t typed);
    script_row_t row;
    row.beat.cmd = cmd;
    row.beat.data_byte = b;
    row.beat.first_byte = fb;
    row.beat.transfer_length = len;
    row.how = how;
    row.typed = typed;
    script.insert(script.size(), row);
  endtask

  // Register writes keep cfg_valid high between them; the caller lowers it.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [FRAME_LENGTH_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MIN_FRAME_LENGTH)
      min_len = value;
    else if (idx == REG_MAX_FRAME_LENGTH)
      max_len = value;
  endtask

  task automatic configure(input logic [FRAME_LENGTH_BITS-1:0] lo,
                           input logic [FRAME_LENGTH_BITS-1:0] hi);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_MIN_FRAME_LENGTH, lo);
      write_reg(REG_MAX_FRAME_LENGTH, hi);
    end else begin
      write_reg(REG_MAX_FRAME_LENGTH, hi);
      write_reg(REG_MIN_FRAME_LENGTH, lo);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random sequence: mostly whole transfers with random content, the rest broken
  // transfers, overlong transfers, bad headers, stall events and loose noise beats.
  task automatic send_random_sequence();
    item_t       it;
    int unsigned pick;
    int unsigned tlen;
    int unsigned hlen;
    int unsigned nbeats;
    int unsigned extra;
    logic [7:0]  info;
    it = '0;
    extra = 0;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      it.cmd = CMD_STALL;
      it.data_byte = 8'($urandom);
      it.first_byte = 1'($urandom);
      it.transfer_length = 16'($urandom);
      send_beat(it, ROW_PREDICTED, '0);
    end else if (pick < 12) begin
      repeat ($urandom_range(1, 4)) begin
        it.cmd = CMD_BYTE;
        it.data_byte = 8'($urandom);
        it.first_byte = ($urandom_range(0, 3) == 0);
        it.transfer_length = 16'($urandom);
        send_beat(it, ROW_PREDICTED, '0);
      end
    end else begin
      tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(2, 24);
      if ($urandom_range(0, 4) == 0 && tlen <= 255)
        hlen = tlen;
      else
        hlen = $urandom_range(2, (tlen < 12) ? tlen : 12);
      if ($urandom_range(0, 2) == 0)
        next_fid = ~next_fid;
      info = (8'($urandom) & 8'hBC) | (next_fid ? INFO_FID : 8'h00) |
             (($urandom_range(0, 3) == 0) ? INFO_EOF : 8'h00);
      nbeats = tlen;
      if (pick < 22) begin
        case ($urandom_range(0, 3))
          0: info = info | INFO_ERR;
          1: hlen = $urandom_range(0, 1);
          2: begin
            tlen = $urandom_range(2, 20);
            hlen = $urandom_range(tlen + 1, 255);
            nbeats = tlen;
          end
          default: begin
            tlen = $urandom_range(0, 1);
            nbeats = 2 + $urandom_range(0, 2);
          end
        endcase
      end else if (pick < 32) begin
        // Cut short; the next first byte or a stall abandons it.
        nbeats = $urandom_range(1, tlen - 1);
      end else if (pick < 38) begin
        extra = $urandom_range(1, 3);
      end
      for (int unsigned i = 0; i < nbeats + extra; i++) begin
        it.cmd = CMD_BYTE;
        it.first_byte = (i == 0);
        it.data_byte = (i == 0) ? hlen[7:0] : (i == 1) ? info : 8'($urandom);
        it.transfer_length = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'(tlen);
        send_beat(it, ROW_PREDICTED, '0);
      end
      if (pick >= 22 && pick < 27) begin
        it.cmd = CMD_STALL;
        send_beat(it, ROW_PREDICTED, '0);
      end
    end
  endtask

  initial begin
    int    target;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows run with the reset settings: no minimum, no cap.
    add_row(CMD_STALL, 8'h00, 1'b0, 16'd0, ROW_TYPED,
            mk_result(KIND_CLEAR_HALT, 8'h00, '0, 1'b0));
    add_row(CMD_BYTE, 8'hFF, 1'b0, 16'hFFFF, ROW_SILENT, '0);      // stray byte
    add_row(CMD_BYTE, 8'h02, 1'b1, 16'd5, ROW_SILENT, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 16'd5, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b0, 16'd5, ROW_TYPED, mk_result(KIND_DATA, 8'hFF, '0, 1'b0));
    add_row(CMD_BYTE, 8'h00, 1'b0, 16'd5, ROW_TYPED, mk_result(KIND_DATA, 8'h00, '0, 1'b0));
    add_row(CMD_BYTE, 8'h5A, 1'b0, 16'd5, ROW_TYPED, mk_result(KIND_DATA, 8'h5A, '0, 1'b0));
    add_row(CMD_BYTE, 8'h77, 1'b0, 16'd5, ROW_SILENT, '0);         // past the length
    add_row(CMD_BYTE, 8'h02, 1'b1, 16'd2, ROW_SILENT, '0);
    add_row(CMD_BYTE, 8'h03, 1'b0, 16'd2, ROW_PREDICTED, '0);      // toggle, header only
    add_row(CMD_BYTE, 8'hFF, 1'b1, 16'hFFFF, ROW_SILENT, '0);
    add_row(CMD_BYTE, INFO_ERR, 1'b0, 16'hFFFF, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'h02, 1'b1, 16'd0, ROW_SILENT, '0);         // abandons the open one
    add_row(CMD_BYTE, 8'h00, 1'b0, 16'd0, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'h01, 1'b1, 16'd4, ROW_SILENT, '0);
    add_row(CMD_BYTE, 8'h01, 1'b0, 16'd4, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'h09, 1'b1, 16'd4, ROW_SILENT, '0);
    add_row(CMD_BYTE, 8'h01, 1'b0, 16'd4, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'h03, 1'b1, 16'd4, ROW_SILENT, '0);
    add_row(CMD_BYTE, INFO_EOF, 1'b0, 16'd4, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'hBB, 1'b0, 16'd4, ROW_PREDICTED, '0);
    add_row(CMD_BYTE, 8'h3C, 1'b0, 16'd4, ROW_PREDICTED, '0);      // data and frame end
    add_row(CMD_BYTE, 8'h02, 1'b1, 16'd6, ROW_SILENT, '0);
    add_row(CMD_BYTE, 8'h00, 1'b0, 16'd6, ROW_PREDICTED, '0);
    add_row(CMD_STALL, 8'hFF, 1'b1, 16'hFFFF, ROW_TYPED,
            mk_result(KIND_CLEAR_HALT, 8'h00, '0, 1'b0));
    add_row(CMD_BYTE, 8'h11, 1'b0, 16'd6, ROW_SILENT, '0);
    foreach (script[i])
      send_beat(script[i].beat, script[i].how, script[i].typed);
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(24'd0, 24'hFFFFFF);
        1: configure(24'hFFFFFF, 24'hFFFFFF);
        2: configure(24'd0, 24'd0);
        3: configure(24'($urandom_range(0, 40)), 24'($urandom_range(20, 80)));
        4: configure(24'd1, 24'd16);
        5: configure(24'($urandom_range(0, 60)), 24'($urandom_range(0, 200)));
        6: configure(24'd30, 24'hFFFFFF);
        default: configure(24'($urandom_range(0, 20)), 24'hFFFFFF);
      endcase
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) send_random_sequence();
      in_valid <= 1'b0;
      settle();
    end

    if (mismatches == 0)
      $display("uvc_payload_deframer: match");
    else
      $display("uvc_payload_deframer: mismatch");
    $finish;
  end
endmodule

// ===== uvc_payload_deframer.f =====
design/uvd_pkg.sv
design/uvd_parser.sv
design/uvd_out_fifo.sv
design/uvc_payload_deframer.sv
bench/tb_uvc_payload_deframer.sv
